>>> hw/rtl/wdad_pkg.sv
// ----------------------------------------------------------------------------
// wdad_pkg
// Shared constants, types and codes of the window deviation anomaly detector:
// window geometry, datapath widths, memory and divider request structs, and
// the sequencer state and operation codes.
// ----------------------------------------------------------------------------
package wdad_pkg;

    // Window geometry
    localparam int WINDOW      = 20;
    localparam int MIN_HISTORY = 10;
    localparam int COUNT_CAP   = (WINDOW > MIN_HISTORY) ? WINDOW : MIN_HISTORY;

    // Metrics per sample and their width (unsigned Q16.16)
    localparam int NUM_M   = 3;
    localparam int M_IDX_W = $clog2(NUM_M);
    localparam int MET_W   = 32;
    localparam int FRAC_W  = 16;

    // State widths
    localparam int PTR_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(COUNT_CAP + 1);
    localparam int SUM_W = MET_W + $clog2(WINDOW);

    // Deviation widths: one quotient and the sum of three of them
    localparam int DEV_W  = MET_W + FRAC_W;
    localparam int K_W    = $clog2(NUM_M + 1);
    localparam int DSUM_W = DEV_W + $clog2(NUM_M);

    // Shared divider: left-aligned dividend, 32-bit divisor
    localparam int DIV_W = (DSUM_W > SUM_W) ? DSUM_W : SUM_W;
    localparam int DVS_W = MET_W;
    localparam int NB_W  = $clog2(DIV_W + 1);

    // Ring memory: one row holds all three metrics of a sample
    localparam int ROW_W = NUM_M * MET_W;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int IDX_W  = ADDR_W - 2;
    localparam int DATA_W = 32;
    localparam logic [IDX_W-1:0] REG_THRESHOLD   = '0;
    localparam logic [MET_W-1:0] THRESHOLD_RESET = 32'h0000_8000;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ADD,
        S_START,
        S_WAIT,
        S_OUT
    } t_state;

    // Divider operations, in the order they run
    typedef enum logic [1:0] {
        OP_BASE,
        OP_DEV,
        OP_MEAN
    } t_op;

    // Ring memory write and read requests
    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] addr;
        logic [ROW_W-1:0] data;
    } t_ram_wr;

    typedef struct packed {
        logic             re;
        logic [PTR_W-1:0] addr;
    } t_ram_rd;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
        logic [NB_W-1:0]  nbits;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

>>> hw/rtl/wdad_if.sv
// ----------------------------------------------------------------------------
// wdad_if
// Valid/ready channels of the detector: sample input and result output.
// ----------------------------------------------------------------------------

// Sample channel: one transfer carries three metrics
interface wdad_sample_if;
    logic                      valid;
    logic                      ready;
    logic [wdad_pkg::MET_W-1:0] cov_gain;
    logic [wdad_pkg::MET_W-1:0] exec_speed;
    logic [wdad_pkg::MET_W-1:0] mem_efficiency;

    modport source (
        output valid, cov_gain, exec_speed, mem_efficiency,
        input  ready
    );
    modport sink (
        input  valid, cov_gain, exec_speed, mem_efficiency,
        output ready
    );
endinterface

// Result channel: one transfer per sample
interface wdad_result_if;
    logic                      valid;
    logic                      ready;
    logic                      checked;
    logic                      anomaly;
    logic [wdad_pkg::MET_W-1:0] deviation;

    modport source (
        output valid, checked, anomaly, deviation,
        input  ready
    );
    modport sink (
        input  valid, checked, anomaly, deviation,
        output ready
    );
endinterface

>>> hw/rtl/wdad_ring_ram.sv
// ----------------------------------------------------------------------------
// wdad_ring_ram
// Sample ring: one write port, one read port, registered read data.
// Each row holds the three metrics of one sample.
// ----------------------------------------------------------------------------
module wdad_ring_ram (
    input  logic                        i_clk,
    input  wdad_pkg::t_ram_wr           i_wr,
    input  wdad_pkg::t_ram_rd           i_rd,
    output logic [wdad_pkg::ROW_W-1:0]  o_rdata
);

    logic [wdad_pkg::ROW_W-1:0] r_mem [wdad_pkg::WINDOW];
    logic [wdad_pkg::ROW_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd.re) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/wdad_div.sv
// ----------------------------------------------------------------------------
// wdad_div
// Shared restoring divider, one quotient bit per cycle. The dividend comes
// left-aligned; nbits says how many of its top bits to process. done pulses
// for one cycle with the quotient in the low nbits bits.
// ----------------------------------------------------------------------------
module wdad_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wdad_pkg::t_div_req i_req,
    output wdad_pkg::t_div_rsp o_rsp
);

    logic                        r_busy;
    logic                        r_done;
    logic [wdad_pkg::NB_W-1:0]   r_cnt;
    logic [wdad_pkg::DVS_W-1:0]  r_rem;
    logic [wdad_pkg::DIV_W-1:0]  r_dvd;
    logic [wdad_pkg::DIV_W-1:0]  r_quo;
    logic [wdad_pkg::DVS_W-1:0]  r_dvs;

    logic [wdad_pkg::DVS_W:0]    trial;
    logic [wdad_pkg::DVS_W:0]    diff;
    logic                        ge;

    // One restoring step: shift in next dividend bit, trial subtract
    always_comb begin
        trial = {r_rem, r_dvd[wdad_pkg::DIV_W-1]};
        diff  = trial - {1'b0, r_dvs};
        ge    = (trial >= {1'b0, r_dvs});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == wdad_pkg::NB_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_quo <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[wdad_pkg::DVS_W-1:0] : trial[wdad_pkg::DVS_W-1:0];
            r_dvd <= r_dvd << 1;
            r_quo <= {r_quo[wdad_pkg::DIV_W-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

>>> hw/rtl/wdad_core.sv
// ----------------------------------------------------------------------------
// wdad_core
// Sequencer of the detector. Reads the old ring row, updates the window sums,
// writes the new sample back and, once enough history is held, runs baselines,
// per-metric deviations and their mean through the shared divider. It then
// loads the result register.
module wdad_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    wdad_sample_if.sink                  i_sample,
    wdad_result_if.source                o_result,
    input  logic [wdad_pkg::MET_W-1:0]   i_threshold,
    output wdad_pkg::t_ram_wr            o_ram_wr,
    output wdad_pkg::t_ram_rd            o_ram_rd,
    input  logic [wdad_pkg::ROW_W-1:0]   i_ram_rdata,
    output wdad_pkg::t_div_req           o_div_req,
    input  wdad_pkg::t_div_rsp           i_div_rsp
);

    localparam int NM = wdad_pkg::NUM_M;
    localparam logic [wdad_pkg::M_IDX_W-1:0] LAST_M = wdad_pkg::M_IDX_W'(NM - 1);

    // Control state
    wdad_pkg::t_state r_state, n_state;
    wdad_pkg::t_op    r_op, n_op;
    logic [wdad_pkg::M_IDX_W-1:0] r_m, n_m;
    logic [wdad_pkg::PTR_W-1:0]   r_ptr, n_ptr;
    logic [wdad_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [wdad_pkg::SUM_W-1:0]   r_sum [NM];
    logic [wdad_pkg::SUM_W-1:0]   n_sum [NM];
    logic                         r_out_valid, n_out_valid;

    // Payload
    logic [wdad_pkg::MET_W-1:0]   r_cur  [NM];
    logic [wdad_pkg::MET_W-1:0]   n_cur  [NM];
    logic [wdad_pkg::MET_W-1:0]   r_base [NM];
    logic [wdad_pkg::MET_W-1:0]   n_base [NM];
    logic [wdad_pkg::DSUM_W-1:0]  r_dsum, n_dsum;
    logic [wdad_pkg::K_W-1:0]     r_k, n_k;
    logic [wdad_pkg::DIV_W-1:0]   r_mean, n_mean;
    logic                         r_checked, n_checked;
    logic                         r_out_checked, n_out_checked;
    logic                         r_out_anomaly, n_out_anomaly;
    logic [wdad_pkg::MET_W-1:0]   r_out_dev, n_out_dev;

    // Helpers
    logic                         accept;
    logic                         full;
    logic [wdad_pkg::CNT_W-1:0]   cnt_inc;
    logic [wdad_pkg::CNT_W-1:0]   navg;
    logic [wdad_pkg::MET_W-1:0]   cur_m;
    logic [wdad_pkg::MET_W-1:0]   base_m;
    logic [wdad_pkg::MET_W-1:0]   absdiff;

    assign accept = i_sample.valid && (r_state == wdad_pkg::S_IDLE);
    assign full   = (r_cnt >= wdad_pkg::CNT_W'(wdad_pkg::WINDOW));
    assign navg   = (r_cnt < wdad_pkg::CNT_W'(wdad_pkg::WINDOW)) ?
                    r_cnt : wdad_pkg::CNT_W'(wdad_pkg::WINDOW);
    assign cnt_inc = (r_cnt < wdad_pkg::CNT_W'(wdad_pkg::COUNT_CAP)) ?
                     r_cnt + 1'b1 : r_cnt;

    // |current - baseline| of the metric in turn
    assign cur_m   = r_cur[r_m];
    assign base_m  = r_base[r_m];
    assign absdiff = (cur_m >= base_m) ? cur_m - base_m : base_m - cur_m;

    // Next state and outputs
    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_m           = r_m;
        n_ptr         = r_ptr;
        n_cnt         = r_cnt;
        n_sum         = r_sum;
        n_cur         = r_cur;
        n_base        = r_base;
        n_dsum        = r_dsum;
        n_k           = r_k;
        n_mean        = r_mean;
        n_checked     = r_checked;
        n_out_checked = r_out_checked;
        n_out_anomaly = r_out_anomaly;
        n_out_dev     = r_out_dev;
        n_out_valid   = r_out_valid && !o_result.ready;

        o_ram_rd      = '0;
        o_ram_wr      = '0;
        o_div_req     = '0;

        case (r_state)
            // Take a sample and fetch the row it replaces
            wdad_pkg::S_IDLE: begin
                if (accept) begin
                    n_cur[0]      = i_sample.cov_gain;
                    n_cur[1]      = i_sample.exec_speed;
                    n_cur[2]      = i_sample.mem_efficiency;
                    o_ram_rd.re   = 1'b1;
                    o_ram_rd.addr = r_ptr;
                    n_state       = wdad_pkg::S_READ;
                end
            end

            // Drop the oldest sample from the sums once the ring is full; write the new row
            wdad_pkg::S_READ: begin
                for (int i = 0; i < NM; i++) begin
                    if (full) begin
                        n_sum[i] = r_sum[i] - wdad_pkg::SUM_W'(
                            i_ram_rdata[i*wdad_pkg::MET_W +: wdad_pkg::MET_W]);
                    end
                    o_ram_wr.data[i*wdad_pkg::MET_W +: wdad_pkg::MET_W] = r_cur[i];
                end
                o_ram_wr.we   = 1'b1;
                o_ram_wr.addr = r_ptr;
                n_state       = wdad_pkg::S_ADD;
            end

            // Add the new sample, advance pointer and count
            wdad_pkg::S_ADD: begin
                for (int i = 0; i < NM; i++) begin
                    n_sum[i] = r_sum[i] + wdad_pkg::SUM_W'(r_cur[i]);
                end
                n_ptr = (r_ptr == wdad_pkg::PTR_W'(wdad_pkg::WINDOW - 1)) ?
                        '0 : r_ptr + 1'b1;
                n_cnt     = cnt_inc;
                n_checked = (cnt_inc >= wdad_pkg::CNT_W'(wdad_pkg::MIN_HISTORY));
                n_dsum    = '0;
                n_k       = '0;
                n_mean    = '0;
                n_op      = wdad_pkg::OP_BASE;
                n_m       = '0;
                n_state   = n_checked ? wdad_pkg::S_START : wdad_pkg::S_OUT;
            end

            // Issue the next division, skipping zero baselines
            wdad_pkg::S_START: begin
                case (r_op)
                    wdad_pkg::OP_BASE: begin
                        o_div_req.start    = 1'b1;
                        o_div_req.dividend = wdad_pkg::DIV_W'(r_sum[r_m])
                                             << (wdad_pkg::DIV_W - wdad_pkg::SUM_W);
                        o_div_req.divisor  = wdad_pkg::DVS_W'(navg);
                        o_div_req.nbits    = wdad_pkg::NB_W'(wdad_pkg::SUM_W);
                        n_state            = wdad_pkg::S_WAIT;
                    end
                    wdad_pkg::OP_DEV: begin
                        if (base_m == '0) begin
                            if (r_m == LAST_M) begin
                                n_op = wdad_pkg::OP_MEAN;
                                n_m  = '0;
                            end else begin
                                n_m = r_m + 1'b1;
                            end
                        end else begin
                            o_div_req.start    = 1'b1;
                            o_div_req.dividend = wdad_pkg::DIV_W'(absdiff)
                                                 << (wdad_pkg::DIV_W - wdad_pkg::MET_W);
                            o_div_req.divisor  = base_m;
                            o_div_req.nbits    = wdad_pkg::NB_W'(wdad_pkg::DEV_W);
                            n_state            = wdad_pkg::S_WAIT;
                        end
                    end
                    wdad_pkg::OP_MEAN: begin
                        if (r_k == '0) begin
                            n_mean  = '0;
                            n_state = wdad_pkg::S_OUT;
                        end else begin
                            o_div_req.start    = 1'b1;
                            o_div_req.dividend = wdad_pkg::DIV_W'(r_dsum)
                                                 << (wdad_pkg::DIV_W - wdad_pkg::DSUM_W);
                            o_div_req.divisor  = wdad_pkg::DVS_W'(r_k);
                            o_div_req.nbits    = wdad_pkg::NB_W'(wdad_pkg::DSUM_W);
                            n_state            = wdad_pkg::S_WAIT;
                        end
                    end
                    default: begin
                        n_state = wdad_pkg::S_IDLE;
                    end
                endcase
            end

            // Collect the quotient
            wdad_pkg::S_WAIT: begin
                if (i_div_rsp.done) begin
                    n_state = wdad_pkg::S_START;
                    case (r_op)
                        wdad_pkg::OP_BASE: begin
                            n_base[r_m] = i_div_rsp.quotient[wdad_pkg::MET_W-1:0];
                            if (r_m == LAST_M) begin
                                n_op = wdad_pkg::OP_DEV;
                                n_m  = '0;
                            end else begin
                                n_m = r_m + 1'b1;
                            end
                        end
                        wdad_pkg::OP_DEV: begin
                            n_dsum = r_dsum + wdad_pkg::DSUM_W'(
                                i_div_rsp.quotient[wdad_pkg::DEV_W-1:0]);
                            n_k    = r_k + 1'b1;
                            if (r_m == LAST_M) begin
                                n_op = wdad_pkg::OP_MEAN;
                                n_m  = '0;
                            end else begin
                                n_m = r_m + 1'b1;
                            end
                        end
                        wdad_pkg::OP_MEAN: begin
                            n_mean  = i_div_rsp.quotient;
                            n_state = wdad_pkg::S_OUT;
                        end
                        default: begin
                            n_state = wdad_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            // Load the result register once it is free
            wdad_pkg::S_OUT: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_checked = r_checked;
                    n_out_anomaly = r_checked &&
                                    (r_mean > wdad_pkg::DIV_W'(i_threshold));
                    n_out_dev     = (r_mean[wdad_pkg::DIV_W-1:wdad_pkg::MET_W] != '0) ?
                                    '1 : r_mean[wdad_pkg::MET_W-1:0];
                    n_state       = wdad_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = wdad_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wdad_pkg::S_IDLE;
            r_op        <= wdad_pkg::OP_BASE;
            r_m         <= '0;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NM; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_m         <= n_m;
            r_ptr       <= n_ptr;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_sum       <= n_sum;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur         <= n_cur;
        r_base        <= n_base;
        r_dsum        <= n_dsum;
        r_k           <= n_k;
        r_mean        <= n_mean;
        r_checked     <= n_checked;
        r_out_checked <= n_out_checked;
        r_out_anomaly <= n_out_anomaly;
        r_out_dev     <= n_out_dev;
    end

    assign i_sample.ready     = (r_state == wdad_pkg::S_IDLE);
    assign o_result.valid     = r_out_valid;
    assign o_result.checked   = r_out_checked;
    assign o_result.anomaly   = r_out_anomaly;
    assign o_result.deviation = r_out_dev;

endmodule

>>> hw/rtl/window_deviation_anomaly_detector_unit.sv
// ----------------------------------------------------------------------------
// window_deviation_anomaly_detector_unit
// Moving-window relative deviation anomaly detector, top level. Holds the
// threshold register behind the APB port and ties the sequencer, the sample
// ring and the shared divider together.
//
//   channel   dir   handshake      payload
//   i_sample  in    valid/ready    cov_gain, exec_speed, mem_efficiency
//   o_result  out   valid/ready    checked, anomaly, deviation
//   apb       in    psel/penable   paddr, pwdata -> threshold
//
// A sample with too little history skips the divider and goes from the read
// and add states straight to the output state. A checked sample runs up to
// seven divisions through one divider that makes one quotient bit a cycle,
// fewer when baselines are zero. One sample is in work at a time; the next
// is taken while the previous result still waits in the output register.
// Reset is synchronous; the ring needs no clearing pass.
// ----------------------------------------------------------------------------
module window_deviation_anomaly_detector_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    wdad_sample_if.sink                   i_sample,
    wdad_result_if.source                 o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wdad_pkg::ADDR_W-1:0]   paddr,
    input  logic [wdad_pkg::DATA_W-1:0]   pwdata,
    output logic [wdad_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [wdad_pkg::MET_W-1:0]  r_threshold;
    logic [wdad_pkg::IDX_W-1:0]  reg_idx;
    logic                        wr_en;

    wdad_pkg::t_ram_wr           ram_wr;
    wdad_pkg::t_ram_rd           ram_rd;
    logic [wdad_pkg::ROW_W-1:0]  ram_rdata;
    wdad_pkg::t_div_req          div_req;
    wdad_pkg::t_div_rsp          div_rsp;

    // APB register access
    assign pready  = 1'b1;
    assign reg_idx = paddr[wdad_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= wdad_pkg::THRESHOLD_RESET;
        end else if (wr_en && (reg_idx == wdad_pkg::REG_THRESHOLD)) begin
            r_threshold <= pwdata[wdad_pkg::MET_W-1:0];
        end
    end

    assign prdata = (reg_idx == wdad_pkg::REG_THRESHOLD) ?
                    wdad_pkg::DATA_W'(r_threshold) : '0;

    // Sequencer
    wdad_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (i_sample),
        .o_result    (o_result),
        .i_threshold (r_threshold),
        .o_ram_wr    (ram_wr),
        .o_ram_rd    (ram_rd),
        .i_ram_rdata (ram_rdata),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp)
    );

    // Sample ring
    wdad_ring_ram u_ring (
        .i_clk   (i_clk),
        .i_wr    (ram_wr),
        .i_rd    (ram_rd),
        .o_rdata (ram_rdata)
    );

    // Shared divider
    wdad_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

endmodule
